// ----- design/sha_pkg.sv -----
// Shared types, constants and functions for the SHA-256 byte stream hasher.
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] f;
    logic [31:0] g;
    logic [31:0] h;
  } vars_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  localparam logic [7:0][31:0] IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [63:0][31:0] K_TAB = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // Word 0 of each table sits in the highest slot of the packed constant.
  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    return IV[3'd7 - idx];
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    return K_TAB[6'd63 - idx];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
    return (x >> r) | (x << (32 - r));
  endfunction

endpackage

// ----- design/sha_round.sv -----
// One SHA-256 round and one message schedule step.
module sha_round (
  input  sha_pkg::vars_t        vars,
  input  logic [15:0][31:0]     win,
  input  logic [5:0]            round,
  output sha_pkg::vars_t        vars_next,
  output logic [31:0]           sched_word
);
  import sha_pkg::*;

  logic [31:0] w_cur, sg0, sg1, big0, big1, choose, major, t1, t2;

  // win[15] is the word used in this round; win[0] is the newest word.
  always_comb begin
    w_cur = win[15];
    sg0 = rotr(win[14], 7) ^ rotr(win[14], 18) ^ (win[14] >> 3);
    sg1 = rotr(win[1], 17) ^ rotr(win[1], 19) ^ (win[1] >> 10);
    sched_word = win[15] + sg0 + win[6] + sg1;
    big1 = rotr(vars.e, 6) ^ rotr(vars.e, 11) ^ rotr(vars.e, 25);
    choose = (vars.e & vars.f) ^ (~vars.e & vars.g);
    t1 = vars.h + big1 + choose + round_k(round) + w_cur;
    big0 = rotr(vars.a, 2) ^ rotr(vars.a, 13) ^ rotr(vars.a, 22);
    major = (vars.a & vars.b) ^ (vars.a & vars.c) ^ (vars.b & vars.c);
    t2 = big0 + major;
    vars_next.h = vars.g;
    vars_next.g = vars.f;
    vars_next.f = vars.e;
    vars_next.e = vars.d + t1;
    vars_next.d = vars.c;
    vars_next.c = vars.b;
    vars_next.b = vars.a;
    vars_next.a = t1 + t2;
  end

endmodule

// ----- design/sha256_byte_stream_hasher.sv -----
// SHA-256 hasher taking a message one byte per word and returning the digest.
// Input: s_tdata carries the byte, s_tuser says a byte is present, s_tlast marks
// the final word of a message (it may carry no byte, so empty messages work).
// Output: eight words per message, most significant first, m_tlast on the last.
// A word that neither completes a block nor ends the message is taken and
// tready stays high for the next word. A full 64-byte block holds the input
// while the byte buffer is read into the schedule window, the 64 rounds run
// through the single round unit, and the result is added into the chain value.
// On the final word the padding bytes are written one per cycle (up to 64,
// plus one more compression when the length does not fit), then the digest
// words are shown one per cycle while m_tready is high. A stalled receiver
// holds the current digest word and the input stays blocked until all eight
// words are taken. After the last word the chain value, fill count and length
// return to their initial values. Reset clears the control state and loads
// the initial hash; the byte buffer needs no clearing.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // byte_present
  input  logic        s_tlast,   // message_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // digest_word [31:0], word_index [34:32], zeros
  output logic        m_tlast    // last_word
);
  import sha_pkg::*;

  state_t state, state_next;

  logic [7:0]  buf_mem [64];
  logic        mem_we;
  logic [5:0]  mem_waddr;
  logic [7:0]  mem_wdata;
  logic [5:0]  mem_raddr;
  logic [7:0]  mem_rdata;

  logic [7:0][31:0]  chain;
  logic [15:0][31:0] win;
  vars_t             vars, vars_next;
  logic [31:0]       sched_word;
  logic [5:0]        fill;
  logic [60:0]       msg_len;
  logic [63:0]       len_bits;
  logic              pad_first;
  logic              padding;
  logic              finishing;
  logic              len_room;
  logic [6:0]        load_cnt;
  logic              rd_valid;
  logic [5:0]        round;
  logic [2:0]        out_idx;
  logic [7:0]        pad_byte;
  logic              accept;

  sha_round u_round (
    .vars       (vars),
    .win        (win),
    .round      (round),
    .vars_next  (vars_next),
    .sched_word (sched_word)
  );

  assign accept = s_tvalid && s_tready;
  assign len_bits = {msg_len, 3'b000};

  // The length goes into a block only when the 0x80 byte left room for it.
  always_comb begin
    if (pad_first) begin
      pad_byte = PAD_BYTE;
    end else if (fill < LEN_OFFSET || !len_room) begin
      pad_byte = '0;
    end else begin
      pad_byte = len_bits[{3'd7 - fill[2:0], 3'b000} +: 8];
    end
  end

  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    mem_we = 1'b0;
    mem_waddr = fill;
    mem_wdata = s_tdata;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          mem_we = s_tuser;
          if (s_tuser && fill == 6'd63) begin
            state_next = ST_LOAD;
          end else if (s_tlast) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        mem_we = 1'b1;
        mem_wdata = pad_byte;
        if (fill == 6'd63) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (load_cnt[6] && rd_valid) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round == 6'd63) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        if (finishing) begin
          state_next = ST_OUT;
        end else if (padding) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready && out_idx == 3'd7) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign mem_raddr = load_cnt[5:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      buf_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= buf_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= IV;
      fill <= '0;
      msg_len <= '0;
      pad_first <= 1'b0;
      padding <= 1'b0;
      finishing <= 1'b0;
      len_room <= 1'b0;
      load_cnt <= '0;
      rd_valid <= 1'b0;
      round <= '0;
      out_idx <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          load_cnt <= '0;
          rd_valid <= 1'b0;
          if (accept) begin
            if (s_tuser) begin
              fill <= fill + 6'd1;
              msg_len <= msg_len + 61'd1;
            end
            padding <= s_tlast;
            pad_first <= s_tlast;
            finishing <= 1'b0;
          end
        end
        ST_PAD: begin
          fill <= fill + 6'd1;
          pad_first <= 1'b0;
          load_cnt <= '0;
          rd_valid <= 1'b0;
          if (pad_first) begin
            len_room <= fill < LEN_OFFSET;
          end
          // The last length byte lands at the end of a block.
          if (fill == 6'd63 && !pad_first && len_room) begin
            finishing <= 1'b1;
          end
        end
        ST_LOAD: begin
          if (!load_cnt[6]) begin
            load_cnt <= load_cnt + 7'd1;
          end
          rd_valid <= !load_cnt[6];
          round <= '0;
        end
        ST_ROUND: begin
          round <= round + 6'd1;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[7 - i] <= chain[7 - i] + vars[(7 - i) * 32 +: 32];
          end
          out_idx <= '0;
          len_room <= 1'b1;
        end
        ST_OUT: begin
          if (m_tready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              chain <= IV;
              fill <= '0;
              msg_len <= '0;
              padding <= 1'b0;
              finishing <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Schedule window and working variables need no reset.
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      if (rd_valid) begin
        win <= {win[15][23:0], win[14:0], mem_rdata};
      end
      vars <= chain;
    end else if (state == ST_ROUND) begin
      vars <= vars_next;
      win <= {win[14:0], sched_word};
    end
  end

  assign m_tdata = {5'b00000, out_idx, chain[3'd7 - out_idx]};
  assign m_tlast = out_idx == 3'd7;

  a_out_only_when_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> finishing && fill == '0)
    else $error("digest shown before the final block was compressed");
  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid && !padding)
    else $error("input accepted while a message is being finished");
  a_restart_iv: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> chain == IV && msg_len == '0)
    else $error("chain value not restored after the digest");
  a_load_from_full: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_LOAD) |-> fill == '0)
    else $error("compression started on a partial block");

endmodule

// ----- tb/sv/tb_sha256_byte_stream_hasher.sv -----
// Testbench for the SHA-256 byte stream hasher: random messages checked against a model.
`timescale 1ns / 1ps

class digest_board;
  logic [31:0] chain[8];
  logic [7:0]  blk[64];
  int unsigned fill;
  logic [60:0] msg_len;
  logic [31:0] exp_word[$];
  logic [2:0]  exp_idx[$];
  bit          exp_last[$];
  int          errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    chain[0] = 32'h6a09e667; chain[1] = 32'hbb67ae85;
    chain[2] = 32'h3c6ef372; chain[3] = 32'ha54ff53a;
    chain[4] = 32'h510e527f; chain[5] = 32'h9b05688c;
    chain[6] = 32'h1f83d9ab; chain[7] = 32'h5be0cd19;
    fill = 0;
    msg_len = '0;
  endfunction

  function logic [31:0] ror(logic [31:0] x, int r);
    return (x >> r) | (x << (32 - r));
  endfunction

  function void compress();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    logic [31:0] kt[64];
    kt = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
             + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kt[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endfunction

  function void absorb(logic [7:0] b);
    blk[fill] = b;
    fill = (fill + 1) % 64;
    if (fill == 0) compress();
  endfunction

  // Notes one accepted input word and queues the digest if it ends a message.
  function void note_input(logic [7:0] data, bit present, bit fin);
    logic [63:0] bits;
    if (present) begin
      msg_len++;
      absorb(data);
    end
    if (!fin) return;
    bits = {msg_len, 3'b000};
    absorb(8'h80);
    while (fill != 56) absorb(8'h00);
    for (int i = 0; i < 8; i++) absorb(bits[63 - 8*i -: 8]);
    for (int i = 0; i < 8; i++) begin
      exp_word = {exp_word, chain[i]};
      exp_idx = {exp_idx, i[2:0]};
      exp_last = {exp_last, bit'(i == 7)};
    end
    restart();
  endfunction

  function void check_output(logic [39:0] data, bit last);
    logic [31:0] ew;
    logic [2:0]  ei;
    bit          el;
    if (exp_word.size() == 0) begin
      $display("%0t: unexpected digest word %h", $time, data);
      errors++;
      return;
    end
    ew = exp_word.pop_front(); ei = exp_idx.pop_front(); el = exp_last.pop_front();
    if (data[31:0] !== ew) begin
      $display("%0t: digest_word expected %h actual %h", $time, ew, data[31:0]);
      errors++;
    end
    if (data[34:32] !== ei) begin
      $display("%0t: word_index expected %0d actual %0d", $time, ei, data[34:32]);
      errors++;
    end
    if (data[39:35] !== 5'd0) begin
      $display("%0t: pad bits expected 0 actual %h", $time, data[39:35]);
      errors++;
    end
    if (last !== el) begin
      $display("%0t: last_word expected %0b actual %0b", $time, el, last);
      errors++;
    end
  endfunction

  function int pending();
    return exp_word.size();
  endfunction
endclass

module tb_sha256_byte_stream_hasher;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  digest_board board = new();
  int send_idle_pct = 21;
  int recv_idle_pct = 59;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  sha256_byte_stream_hasher uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (s_tvalid && s_tready) board.note_input(s_tdata, s_tuser, s_tlast);
      if (m_tvalid && m_tready) board.check_output(m_tdata, m_tlast);
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      // A full block plus a padding block and a stalled output stay well below this.
      if (quiet_cycles > 5000) begin
        $display("tb_sha256_byte_stream_hasher: FAIL");
        $finish;
      end
    end
  end

  task automatic send_word(logic [7:0] data, bit present, bit fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= data;
    s_tuser  <= present;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_message(int unsigned len, bit end_has_byte);
    int unsigned n;
    n = (end_has_byte && len > 0) ? len - 1 : len;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_word(8'($urandom_range(255)), 0, 0);
      send_word(8'($urandom_range(255)), 1, 0);
    end
    if (end_has_byte && len > 0) send_word(8'($urandom_range(255)), 1, 1);
    else send_word(8'($urandom_range(255)), 0, 1);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  int sent;

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty message, stray empty words, extreme bytes, byte on the final word.
    send_word(8'hff, 0, 1);
    send_word(8'h00, 0, 0);
    send_word(8'h00, 1, 0);
    send_word(8'hff, 1, 1);
    send_word(8'h61, 1, 0);
    send_word(8'h62, 1, 0);
    send_word(8'h63, 0, 0);
    send_word(8'h63, 1, 0);
    send_word(8'h00, 0, 1);
    send_word(8'haa, 1, 1);
    send_word(8'h55, 1, 1);
    drain();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 21; recv_idle_pct = 59; end
        1: begin send_idle_pct = 59; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      // Pad boundaries: length 55 just fits the padding in one block; 56 and 64 push padding into a second block.
      if (p == 0) begin
        send_message(55, 1);
        send_message(56, 0);
        send_message(64, 1'($urandom_range(1)));
      end
      sent = 0;
      while (sent < 55) begin
        int unsigned len;
        len = ($urandom_range(7) == 0) ? $urandom_range(130) : $urandom_range(12);
        send_message(len, 1'($urandom_range(1)));
        sent += len + 1;
        if ($urandom_range(5) == 0) drain();
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("tb_sha256_byte_stream_hasher: PASS");
    else
      $display("tb_sha256_byte_stream_hasher: FAIL");
    $finish;
  end
endmodule

// ----- sim.f -----
design/sha_pkg.sv
design/sha_round.sv
design/sha256_byte_stream_hasher.sv
tb/sv/tb_sha256_byte_stream_hasher.sv
